/* hdl/ntt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types and constants of the radix-2 NTT engine.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned TwAdrW = 9;
  localparam int unsigned CntW   = 48;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned LogW   = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned MaxLog = 10;

  localparam logic [CmdW-1:0] CMD_WR_DATA = 3'd0;
  localparam logic [CmdW-1:0] CMD_WR_TW   = 3'd1;
  localparam logic [CmdW-1:0] CMD_WR_PERM = 3'd2;
  localparam logic [CmdW-1:0] CMD_RUN     = 3'd3;
  localparam logic [CmdW-1:0] CMD_RD_DATA = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_MODULUS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOG     = 1'd1;

  localparam logic [ValW-1:0] MOD_RESET = 32'd65537;
  localparam logic [LogW-1:0] LOG_RESET = 4'd10;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // data memory write source
  typedef enum logic [2:0] {
    WS_IN,
    WS_RD,
    WS_A,
    WS_SUM,
    WS_DIFF
  } ws_e;

  typedef struct packed {
    logic            dwe;
    logic [IdxW-1:0] dwaddr;
    ws_e             wsel;
    logic [IdxW-1:0] draddr;
    logic            twe;
    logic            pwe;
    logic [IdxW-1:0] paddr;
    logic            w_cap;
    logic            a_cap;
    logic            b_cap;
    logic            prod_cap;
    logic            red_load_u;
    logic            red_load_p;
    logic            red_step;
    logic            u_cap;
    logic            v_cap;
    logic            cnt_inc;
    logic            out_load;
    logic            out_kind;
  } ntt_cmd_t;

  typedef struct packed {
    logic            out_free;
    logic [LogW-1:0] lg;
    logic [IdxW-1:0] perm_rd;
  } ntt_stat_t;

endpackage
`default_nettype wire

/* hdl/ntt_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_in_if
// Command channel: valid/ready with cmd, index and value.
// ----------------------------------------------------------------------------
interface ntt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [9:0]  index;
  logic [31:0] value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink (input valid, input cmd, input index, input value, output ready);
endinterface
`default_nettype wire

/* hdl/ntt_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_out_if
// Result channel: valid/ready with kind, data and mult_count.
// ----------------------------------------------------------------------------
interface ntt_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] data;
  logic [47:0] mult_count;

  modport source (output valid, output kind, output data, output mult_count, input ready);
  modport sink (input valid, input kind, input data, input mult_count, output ready);
endinterface
`default_nettype wire

/* hdl/ntt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_datapath
// Memories, config registers, modular arithmetic and the result register.
// ----------------------------------------------------------------------------
module ntt_datapath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [ntt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [ntt_pkg::ValW-1:0]   cfg_data_i,
  input  wire [ntt_pkg::IdxW-1:0]   in_index_i,
  input  wire [ntt_pkg::ValW-1:0]   in_value_i,
  input  wire ntt_pkg::ntt_cmd_t    cmd_i,
  output ntt_pkg::ntt_stat_t        stat_o,
  input  wire                       out_ready_i,
  output logic                      out_valid_o,
  output logic                      out_kind_o,
  output logic [ntt_pkg::ValW-1:0]  out_data_o,
  output logic [ntt_pkg::CntW-1:0]  out_cnt_o
);
  import ntt_pkg::*;

  logic [ValW-1:0] data_mem [1 << IdxW];
  logic [ValW-1:0] tw_mem   [1 << TwAdrW];
  logic [IdxW-1:0] perm_mem [1 << IdxW];

  logic [ValW-1:0]   mod_q;
  logic [LogW-1:0]   log_q;
  logic [ValW-1:0]   m_eff;
  logic [ValW-1:0]   d_rd_q, tw_rd_q;
  logic [IdxW-1:0]   p_rd_q;
  logic [ValW-1:0]   w_q, a_q, b_q, u_q, v_q;
  logic [2*ValW-1:0] prod_q, x_q;
  logic [ValW-1:0]   r_q;
  logic [ValW:0]     red_t, red_s, sum_t, sum_s, diff_s;
  logic [ValW-1:0]   wdata;
  logic [CntW-1:0]   cnt_q;
  logic              ov_q;

  assign m_eff = (mod_q < 32'd3) ? 32'd3 : mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET;
      log_q <= LOG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS: mod_q <= cfg_data_i;
        CFG_LOG:     log_q <= cfg_data_i[LogW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    stat_o.lg = log_q;
    if (log_q == '0) stat_o.lg = 4'd1;
    else if (log_q > LogW'(MaxLog)) stat_o.lg = LogW'(MaxLog);
    stat_o.perm_rd  = p_rd_q;
    stat_o.out_free = !ov_q || out_ready_i;
  end

  // modular add / sub of reduced operands
  assign sum_t  = {1'b0, u_q} + {1'b0, v_q};
  assign sum_s  = (sum_t >= {1'b0, m_eff}) ? sum_t - {1'b0, m_eff} : sum_t;
  assign diff_s = (u_q >= v_q) ? {1'b0, u_q - v_q}
                               : {1'b0, u_q} + {1'b0, m_eff} - {1'b0, v_q};

  // bit-serial remainder, one bit a cycle
  assign red_t = {r_q, x_q[2*ValW-1]};
  assign red_s = (red_t >= {1'b0, m_eff}) ? red_t - {1'b0, m_eff} : red_t;

  always_comb begin
    case (cmd_i.wsel)
      WS_IN:   wdata = in_value_i;
      WS_RD:   wdata = d_rd_q;
      WS_A:    wdata = a_q;
      WS_SUM:  wdata = sum_s[ValW-1:0];
      WS_DIFF: wdata = diff_s[ValW-1:0];
      default: wdata = in_value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dwe) data_mem[cmd_i.dwaddr] <= wdata;
    d_rd_q <= data_mem[cmd_i.draddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.twe) tw_mem[in_index_i[TwAdrW-1:0]] <= in_value_i;
    tw_rd_q <= tw_mem[p_rd_q[IdxW-1:1]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pwe) perm_mem[in_index_i] <= in_value_i[IdxW-1:0];
    p_rd_q <= perm_mem[cmd_i.paddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_cap)    w_q    <= tw_rd_q;
    if (cmd_i.a_cap)    a_q    <= d_rd_q;
    if (cmd_i.b_cap)    b_q    <= d_rd_q;
    if (cmd_i.prod_cap) prod_q <= b_q * w_q;
    if (cmd_i.u_cap)    u_q    <= r_q;
    if (cmd_i.v_cap)    v_q    <= r_q;
    if (cmd_i.red_load_u) begin
      x_q <= {a_q, {ValW{1'b0}}};
      r_q <= '0;
    end else if (cmd_i.red_load_p) begin
      x_q <= prod_q;
      r_q <= '0;
    end else if (cmd_i.red_step) begin
      x_q <= {x_q[2*ValW-2:0], 1'b0};
      r_q <= red_s[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_o <= cmd_i.out_kind;
      out_data_o <= (cmd_i.out_kind == KIND_DONE) ? '0 : d_rd_q;
      out_cnt_o  <= cnt_q;
    end
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

/* hdl/ntt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_ctrl
// Command decode and butterfly / swap sequencer.
// ----------------------------------------------------------------------------
module ntt_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  input  wire [ntt_pkg::CmdW-1:0]    in_cmd_i,
  input  wire [ntt_pkg::IdxW-1:0]    in_index_i,
  output logic                       in_ready_o,
  input  wire ntt_pkg::ntt_stat_t    stat_i,
  output ntt_pkg::ntt_cmd_t          cmd_o
);
  import ntt_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_INIT = 5'd2;
  localparam logic [4:0] S_BP   = 5'd3;
  localparam logic [4:0] S_BT   = 5'd4;
  localparam logic [4:0] S_BL   = 5'd5;
  localparam logic [4:0] S_BH   = 5'd6;
  localparam logic [4:0] S_BM   = 5'd7;
  localparam logic [4:0] S_RU   = 5'd8;
  localparam logic [4:0] S_UC   = 5'd9;
  localparam logic [4:0] S_RV   = 5'd10;
  localparam logic [4:0] S_VC   = 5'd11;
  localparam logic [4:0] S_WL   = 5'd12;
  localparam logic [4:0] S_WH   = 5'd13;
  localparam logic [4:0] S_WP   = 5'd14;
  localparam logic [4:0] S_WC   = 5'd15;
  localparam logic [4:0] S_WA   = 5'd16;
  localparam logic [4:0] S_WB   = 5'd17;
  localparam logic [4:0] S_WW   = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  logic [4:0]      st_q, st_d;
  logic [8:0]      j_q, j_d, nb_q, nb_d;
  logic [IdxW-1:0] half_q, half_d, lmask_q, lmask_d;
  logic [LogW-1:0] hsh_q, hsh_d;
  logic [IdxW-1:0] i_q, i_d, p_q, p_d;
  logic [5:0]      rc_q, rc_d;
  logic [IdxW-1:0] jx, hmask, lo, hi, grp, pm;
  logic            acc;

  assign in_ready_o = (st_q == S_IDLE) && stat_i.out_free;
  assign acc   = in_valid_i && in_ready_o;
  assign jx    = {1'b0, j_q};
  assign hmask = half_q - 1'b1;
  assign lo    = ((jx & ~hmask) << 1) | (jx & hmask);
  assign hi    = lo | half_q;
  assign grp   = jx >> hsh_q;
  assign pm    = stat_i.perm_rd & lmask_q;

  always_comb begin
    st_d = st_q; j_d = j_q; nb_d = nb_q; half_d = half_q; lmask_d = lmask_q;
    hsh_d = hsh_q; i_d = i_q; p_d = p_q; rc_d = rc_q;
    cmd_o = '0;
    cmd_o.wsel   = WS_IN;
    cmd_o.draddr = in_index_i;
    cmd_o.dwaddr = in_index_i;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          case (in_cmd_i)
            CMD_WR_DATA: cmd_o.dwe = 1'b1;
            CMD_WR_TW:   cmd_o.twe = 1'b1;
            CMD_WR_PERM: cmd_o.pwe = 1'b1;
            CMD_RUN:     st_d = S_INIT;
            CMD_RD_DATA: st_d = S_RD;
            default:     ;
          endcase
        end
      end
      S_RD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = KIND_READ;
        st_d = S_IDLE;
      end
      S_INIT: begin
        half_d  = IdxW'(1) << (stat_i.lg - 1'b1);
        lmask_d = IdxW'((11'd1 << stat_i.lg) - 11'd1);
        nb_d    = 9'((10'd1 << (stat_i.lg - 1'b1)) - 10'd1);
        hsh_d   = stat_i.lg - 1'b1;
        j_d     = '0;
        st_d    = S_BP;
      end
      S_BP: begin
        cmd_o.paddr = grp;
        st_d = S_BT;
      end
      S_BT: begin
        cmd_o.draddr = lo;
        st_d = S_BL;
      end
      S_BL: begin
        cmd_o.w_cap  = 1'b1;
        cmd_o.a_cap  = 1'b1;
        cmd_o.draddr = hi;
        st_d = S_BH;
      end
      S_BH: begin
        cmd_o.b_cap = 1'b1;
        st_d = S_BM;
      end
      S_BM: begin
        cmd_o.prod_cap   = 1'b1;
        cmd_o.red_load_u = 1'b1;
        rc_d = '0;
        st_d = S_RU;
      end
      S_RU: begin
        cmd_o.red_step = 1'b1;
        rc_d = rc_q + 1'b1;
        if (rc_q == 6'd31) st_d = S_UC;
      end
      S_UC: begin
        cmd_o.u_cap      = 1'b1;
        cmd_o.red_load_p = 1'b1;
        rc_d = '0;
        st_d = S_RV;
      end
      S_RV: begin
        cmd_o.red_step = 1'b1;
        rc_d = rc_q + 1'b1;
        if (rc_q == 6'd63) st_d = S_VC;
      end
      S_VC: begin
        cmd_o.v_cap = 1'b1;
        st_d = S_WL;
      end
      S_WL: begin
        cmd_o.dwe    = 1'b1;
        cmd_o.dwaddr = lo;
        cmd_o.wsel   = WS_SUM;
        st_d = S_WH;
      end
      S_WH: begin
        cmd_o.dwe     = 1'b1;
        cmd_o.dwaddr  = hi;
        cmd_o.wsel    = WS_DIFF;
        cmd_o.cnt_inc = 1'b1;
        if (j_q == nb_q) begin
          j_d = '0;
          if (hsh_q == '0) begin
            i_d  = '0;
            st_d = S_WP;
          end else begin
            hsh_d  = hsh_q - 1'b1;
            half_d = half_q >> 1;
            st_d   = S_BP;
          end
        end else begin
          j_d  = j_q + 1'b1;
          st_d = S_BP;
        end
      end
      S_WP: begin
        cmd_o.paddr = i_q;
        st_d = S_WC;
      end
      S_WC: begin
        p_d = pm;
        if (i_q < pm) begin
          cmd_o.draddr = i_q;
          st_d = S_WA;
        end else if (i_q == lmask_q) begin
          st_d = S_DONE;
        end else begin
          i_d  = i_q + 1'b1;
          st_d = S_WP;
        end
      end
      S_WA: begin
        cmd_o.a_cap  = 1'b1;
        cmd_o.draddr = p_q;
        st_d = S_WB;
      end
      S_WB: begin
        cmd_o.dwe    = 1'b1;
        cmd_o.dwaddr = i_q;
        cmd_o.wsel   = WS_RD;
        st_d = S_WW;
      end
      S_WW: begin
        cmd_o.dwe    = 1'b1;
        cmd_o.dwaddr = p_q;
        cmd_o.wsel   = WS_A;
        if (i_q == lmask_q) begin
          st_d = S_DONE;
        end else begin
          i_d  = i_q + 1'b1;
          st_d = S_WP;
        end
      end
      S_DONE: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = KIND_DONE;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; nb_q <= nb_d; half_q <= half_d; lmask_q <= lmask_d;
    hsh_q <= hsh_d; i_q <= i_d; p_q <= p_d; rc_q <= rc_d;
  end
endmodule
`default_nettype wire

/* hdl/radix2_ntt_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix2_ntt_engine
// In-place radix-2 NTT over a configured prime modulus.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command beats (cmd, index, value); out_ch carries result
//   beats (kind, data, mult_count). The cfg port writes modulus (index 0)
//   and log_size (index 1); the user does so only while the engine is idle,
//   as the block does not enforce it. Coefficient, twiddle and permutation
//   writes give no result; back-to-back writes run at one beat per cycle
//   while no result beat waits. A coefficient read passes the data memory
//   read register, then the result register. A transform runs log_size
//   stages of len/2 butterflies, each paced by the bit-serial remainder
//   unit (32 steps for the lower operand, 64 for the product) and the data
//   memory's single read and single write port. The swap pass reads each
//   permutation entry and, where a swap occurs, reads and writes both
//   elements. Input is held off (ready low) for the whole transform.
// Reset: config returns to modulus 65537 and log_size 10, the
//   multiplication count clears; memory contents are not cleared.
// Stall: the result register holds a beat until taken; a new command is
//   accepted in the same cycle the pending result is taken.
// ----------------------------------------------------------------------------
module radix2_ntt_engine (
  input  wire        clk_i,
  input  wire        rst_ni,
  ntt_in_if.sink     in_ch,
  ntt_out_if.source  out_ch,
  input  wire        cfg_we_i,
  input  wire [0:0]  cfg_idx_i,
  input  wire [31:0] cfg_data_i
);
  import ntt_pkg::*;

  ntt_cmd_t  cmd;
  ntt_stat_t stat;

  // sequencer: command decode, loop counters, address generation
  ntt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_cmd_i   (in_ch.cmd),
    .in_index_i (in_ch.index),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memories, modular arithmetic, result register
  ntt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_index_i  (in_ch.index),
    .in_value_i  (in_ch.value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_kind_o  (out_ch.kind),
    .out_data_o  (out_ch.data),
    .out_cnt_o   (out_ch.mult_count)
  );
endmodule
`default_nettype wire
